// File: rtl/core/ttp_pkg.sv
`timescale 1ns / 1ps

package ttp_pkg;

	localparam int INDEX_BITS_DEF = 12;

	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_STORE = 1'b1;

	localparam logic [1:0] KIND_EXACT    = 2'd0;
	localparam logic [1:0] KIND_LOWER    = 2'd1;
	localparam logic [1:0] KIND_UPPER    = 2'd2;
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	typedef struct packed {
		logic               opcode;
		logic [63:0]        position_key;
		logic [5:0]         search_limit;
		logic [5:0]         ply_depth;
		logic               side;
		logic signed [15:0] window_low;
		logic signed [15:0] window_high;
		logic [1:0]         bound_kind;
		logic signed [15:0] score;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] found_score;
	} out_item_t;

	typedef struct packed {
		logic [63:0]        key;
		logic [5:0]         limit;
		logic [5:0]         ply;
		logic [1:0]         kind;
		logic signed [15:0] score;
	} entry_t;

	typedef struct packed {
		logic clear_en;
		logic store_en;
		logic probe_en;
		logic load_result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

// File: rtl/core/ttp_ctrl.sv
`timescale 1ns / 1ps

module ttp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_op,
	output logic                  in_ready,
	input  ttp_pkg::ctrl_sts_t    sts,
	output ttp_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	always_comb begin
		state_d         = state_q;
		cmd.clear_en    = 1'b0;
		cmd.store_en    = 1'b0;
		cmd.probe_en    = 1'b0;
		cmd.load_result = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_op == ttp_pkg::OP_STORE) begin
						cmd.store_en = 1'b1;
					end else begin
						cmd.probe_en = 1'b1;
						state_d      = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/ttp_datapath.sv
`timescale 1ns / 1ps

module ttp_datapath #(
	parameter int INDEX_BITS = ttp_pkg::INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ttp_pkg::in_item_t     in_data,
	input  ttp_pkg::ctrl_cmd_t    cmd,
	output ttp_pkg::ctrl_sts_t    sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ttp_pkg::out_item_t    out_data
);

	localparam int ADDR_W = INDEX_BITS + 1;
	localparam int DEPTH  = 2 ** ADDR_W;

	ttp_pkg::entry_t    entry_mem [DEPTH];
	logic               valid_mem [DEPTH];

	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [ADDR_W-1:0]  in_addr;
	logic [ADDR_W-1:0]  vld_waddr;
	logic               vld_wdata;
	logic               vld_we;

	ttp_pkg::entry_t    rd_entry_s1;
	logic               rd_valid_s1;
	logic [63:0]        probe_key_q;
	logic [5:0]         probe_limit_q;
	logic [5:0]         probe_ply_q;
	logic signed [15:0] probe_alpha_q;
	logic signed [15:0] probe_beta_q;

	logic               match;
	logic               hit;
	logic               out_valid_q;
	ttp_pkg::out_item_t out_data_q;

	assign in_addr = {in_data.side, in_data.position_key[INDEX_BITS-1:0]};

	// clearing sweep of the valid marks after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clear_last = &clr_cnt_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign vld_we    = cmd.clear_en || cmd.store_en;
	assign vld_waddr = cmd.clear_en ? clr_cnt_q : in_addr;
	assign vld_wdata = !cmd.clear_en;

	always_ff @(posedge clk) begin
		if (vld_we) begin
			valid_mem[vld_waddr] <= vld_wdata;
		end
		if (cmd.probe_en) begin
			rd_valid_s1 <= valid_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_en) begin
			entry_mem[in_addr] <= '{key:   in_data.position_key,
			                        limit: in_data.search_limit,
			                        ply:   in_data.ply_depth,
			                        kind:  in_data.bound_kind,
			                        score: in_data.score};
		end
		if (cmd.probe_en) begin
			rd_entry_s1 <= entry_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_en) begin
			probe_key_q   <= in_data.position_key;
			probe_limit_q <= in_data.search_limit;
			probe_ply_q   <= in_data.ply_depth;
			probe_alpha_q <= in_data.window_low;
			probe_beta_q  <= in_data.window_high;
		end
	end

	assign match = rd_valid_s1
		&& (rd_entry_s1.key == probe_key_q)
		&& (rd_entry_s1.limit == probe_limit_q)
		&& (rd_entry_s1.ply == probe_ply_q);

	always_comb begin
		case (rd_entry_s1.kind)
			ttp_pkg::KIND_EXACT: hit = match;
			ttp_pkg::KIND_LOWER: hit = match && ($signed(rd_entry_s1.score) >= probe_beta_q);
			ttp_pkg::KIND_UPPER: hit = match && ($signed(rd_entry_s1.score) <= probe_alpha_q);
			default:             hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_data_q.hit         <= hit;
			out_data_q.found_score <= hit ? rd_entry_s1.score : 16'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_miss_zero_score: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.hit) |-> (out_data_q.found_score == 16'sd0))
		else $error("miss carries a nonzero score");

	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_en |-> (!cmd.store_en && !cmd.probe_en && !cmd.load_result))
		else $error("table access during clearing sweep");

	a_probe_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_en |=> !cmd.store_en && !cmd.probe_en)
		else $error("new item taken before probe result");
`endif

endmodule

// File: rtl/core/transposition_table_probe.sv
`timescale 1ns / 1ps

// Direct-mapped transposition table, one bank per side to move, 2^INDEX_BITS
// entries per bank. A store produces no result; a probe does a registered
// memory read, then the key and bound compare, and produces one result that
// waits in an output register, so the next item is taken while that result
// is still pending. After reset a clearing pass sweeps the valid marks, one
// entry per cycle, over all 2^(INDEX_BITS+1) entries (8192 at the default);
// in_ready stays low until it finishes.
module transposition_table_probe #(
	parameter int INDEX_BITS = ttp_pkg::INDEX_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ttp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ttp_pkg::out_item_t out_data
);

	ttp_pkg::ctrl_cmd_t cmd;
	ttp_pkg::ctrl_sts_t sts;

	ttp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ttp_datapath #(
		.INDEX_BITS (INDEX_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int IDX_W = ttp_pkg::INDEX_BITS_DEF;
	localparam int SLOTS = 1 << IDX_W;
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef logic [IDX_W:0] slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ttp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ttp_pkg::out_item_t out_data;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned lookup_count = 0;

	ttp_pkg::entry_t shadow_entry [2][SLOTS];
	bit shadow_valid [2][SLOTS];
	slot_t filled_slots[$];
	ttp_pkg::out_item_t expected_lookups[$];

	transposition_table_probe dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: long hold-off first, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		ttp_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_lookups.size() == 0) begin
				report($sformatf("lookup %0d: unexpected result hit=%0b score=%0d",
					lookup_count, out_data.hit, out_data.found_score));
			end else begin
				want = expected_lookups.pop_front();
				if (out_data.hit !== want.hit || out_data.found_score !== want.found_score)
					report($sformatf("lookup %0d: expected hit=%0b score=%0d, got hit=%0b score=%0d",
						lookup_count, want.hit, want.found_score,
						out_data.hit, out_data.found_score));
			end
			lookup_count++;
		end
	end

	// table model: stores update the shadow banks, probes queue the expected lookup
	task automatic table_update(input ttp_pkg::in_item_t it);
		logic [IDX_W-1:0] idx;
		ttp_pkg::entry_t e;
		ttp_pkg::out_item_t r;
		logic hit;
		idx = it.position_key[IDX_W-1:0];
		if (it.opcode == ttp_pkg::OP_STORE) begin
			if (!shadow_valid[it.side][idx])
				filled_slots.push_back({it.side, idx});
			shadow_valid[it.side][idx] = 1'b1;
			e.key = it.position_key;
			e.limit = it.search_limit;
			e.ply = it.ply_depth;
			e.kind = it.bound_kind;
			e.score = it.score;
			shadow_entry[it.side][idx] = e;
		end else begin
			hit = 1'b0;
			if (shadow_valid[it.side][idx]) begin
				e = shadow_entry[it.side][idx];
				if (e.key == it.position_key && e.limit == it.search_limit
						&& e.ply == it.ply_depth) begin
					case (e.kind)
						ttp_pkg::KIND_EXACT: hit = 1'b1;
						ttp_pkg::KIND_LOWER: hit = ($signed(e.score) >= $signed(it.window_high));
						ttp_pkg::KIND_UPPER: hit = ($signed(e.score) <= $signed(it.window_low));
						default: hit = 1'b0;
					endcase
				end
			end
			r.hit = hit;
			r.found_score = hit ? e.score : 16'sd0;
			expected_lookups.push_back(r);
		end
	endtask

	task automatic send_item(input ttp_pkg::in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		table_update(it);
	endtask

	function automatic ttp_pkg::in_item_t make_item(input logic op, input logic [63:0] key,
			input logic [5:0] limit, input logic [5:0] ply, input logic side,
			input logic signed [15:0] alpha, input logic signed [15:0] beta,
			input logic [1:0] kind, input logic signed [15:0] score);
		ttp_pkg::in_item_t it;
		it.opcode = op;
		it.position_key = key;
		it.search_limit = limit;
		it.ply_depth = ply;
		it.side = side;
		it.window_low = alpha;
		it.window_high = beta;
		it.bound_kind = kind;
		it.score = score;
		return it;
	endfunction

	function automatic logic signed [15:0] window_near(input logic signed [15:0] s);
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return s;
			default: return s + $signed(16'($urandom_range(6))) - 16'sd3;
		endcase
	endfunction

	function automatic ttp_pkg::in_item_t random_store();
		logic [63:0] key;
		logic [1:0] kind;
		logic signed [15:0] score;
		key = {$urandom, $urandom};
		if ($urandom_range(99) < 60)
			key[IDX_W-1:0] = IDX_W'($urandom_range(31));
		kind = ($urandom_range(9) == 0) ? ttp_pkg::KIND_RESERVED : 2'($urandom_range(2));
		case ($urandom_range(9))
			0: score = 16'sh8000;
			1: score = 16'sh7fff;
			default: score = 16'($urandom);
		endcase
		return make_item(ttp_pkg::OP_STORE, key, 6'($urandom), 6'($urandom), 1'($urandom),
			16'($urandom), 16'($urandom), kind, score);
	endfunction

	function automatic slot_t pick_filled();
		return filled_slots[$urandom_range(filled_slots.size() - 1)];
	endfunction

	// probe aimed at a written entry, mostly matching, sometimes off by key, limit or ply
	function automatic ttp_pkg::in_item_t random_probe(input slot_t slot);
		ttp_pkg::entry_t e;
		ttp_pkg::in_item_t it;
		int unsigned bitpos;
		e = shadow_entry[slot[IDX_W]][slot[IDX_W-1:0]];
		it = make_item(ttp_pkg::OP_PROBE, e.key, e.limit, e.ply, slot[IDX_W],
			window_near(e.score), window_near(e.score), 2'($urandom), 16'($urandom));
		case ($urandom_range(9))
			0: begin
				bitpos = $urandom_range(63, IDX_W);
				it.position_key[bitpos] = ~it.position_key[bitpos];
			end
			1: it.search_limit = it.search_limit + 6'($urandom_range(63, 1));
			2: it.ply_depth = it.ply_depth + 6'($urandom_range(63, 1));
			default: ;
		endcase
		return it;
	endfunction

	task automatic test_directed();
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		k1 = 64'h0123_4567_89ab_c123;
		k2 = 64'hfedc_ba98_7654_3fff;
		k3 = 64'h5a5a_a5a5_0f0f_0555;
		send_idle_pct = 0;
		stall_pct = 0;
		// extremes of key, limit, ply and score, probed right after the store
		send_item(make_item(ttp_pkg::OP_STORE, 64'h0, 6'd0, 6'd0, 1'b0, 16'sh7fff, 16'sh8000,
			ttp_pkg::KIND_EXACT, 16'sh8000));
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h0, 6'd0, 6'd0, 1'b0, 16'sh8000, 16'sh7fff,
			ttp_pkg::KIND_RESERVED, 16'sh7fff));
		send_item(make_item(ttp_pkg::OP_STORE, '1, 6'd63, 6'd63, 1'b1, 16'sh8000, 16'sh7fff,
			ttp_pkg::KIND_EXACT, 16'sh7fff));
		send_item(make_item(ttp_pkg::OP_PROBE, '1, 6'd63, 6'd63, 1'b1, 16'sh7fff, 16'sh8000,
			ttp_pkg::KIND_UPPER, 16'sh8000));
		// same entry, partial match
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h8000_0000_0000_0000, 6'd0, 6'd0, 1'b0,
			16'sd0, 16'sd0, ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h0, 6'd1, 6'd0, 1'b0, 16'sd0, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h0, 6'd0, 6'd1, 1'b0, 16'sd0, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
		// lower bound against beta
		send_item(make_item(ttp_pkg::OP_STORE, k1, 6'd12, 6'd5, 1'b0, 16'sd0, 16'sd0,
			ttp_pkg::KIND_LOWER, 16'sd100));
		send_item(make_item(ttp_pkg::OP_PROBE, k1, 6'd12, 6'd5, 1'b0, 16'sd0, 16'sd100,
			ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, k1, 6'd12, 6'd5, 1'b0, 16'sd0, 16'sd101,
			ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, k1, 6'd12, 6'd5, 1'b0, 16'sd0, 16'sh8000,
			ttp_pkg::KIND_EXACT, 16'sd0));
		// upper bound against alpha
		send_item(make_item(ttp_pkg::OP_STORE, k2, 6'd7, 6'd30, 1'b1, 16'sd0, 16'sd0,
			ttp_pkg::KIND_UPPER, -16'sd50));
		send_item(make_item(ttp_pkg::OP_PROBE, k2, 6'd7, 6'd30, 1'b1, -16'sd50, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, k2, 6'd7, 6'd30, 1'b1, -16'sd51, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, k2, 6'd7, 6'd30, 1'b1, 16'sh7fff, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
		// bound kind three never hits
		send_item(make_item(ttp_pkg::OP_STORE, k3, 6'd40, 6'd2, 1'b0, 16'sd0, 16'sd0,
			ttp_pkg::KIND_RESERVED, 16'sd5));
		send_item(make_item(ttp_pkg::OP_PROBE, k3, 6'd40, 6'd2, 1'b0, 16'sh7fff, 16'sh8000,
			ttp_pkg::KIND_EXACT, 16'sd0));
		// overwrite and the other bank at the same index
		send_item(make_item(ttp_pkg::OP_STORE, 64'h1234_0000_0000_0000, 6'd0, 6'd0, 1'b0,
			16'sd0, 16'sd0, ttp_pkg::KIND_EXACT, 16'sd7));
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h0, 6'd0, 6'd0, 1'b0, 16'sd0, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h1234_0000_0000_0000, 6'd0, 6'd0, 1'b0,
			16'sd0, 16'sd0, ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_STORE, 64'h0, 6'd0, 6'd0, 1'b1, 16'sd0, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd9));
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h0, 6'd0, 6'd0, 1'b1, 16'sd0, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
		send_item(make_item(ttp_pkg::OP_PROBE, 64'h0, 6'd0, 6'd0, 1'b0, 16'sd0, 16'sd0,
			ttp_pkg::KIND_EXACT, 16'sd0));
	endtask

	task automatic test_random(input int unsigned n_items, input int unsigned src_idle,
			input int unsigned sink_stall);
		int unsigned sent;
		ttp_pkg::in_item_t it;
		sent = 0;
		send_idle_pct = src_idle;
		stall_pct = sink_stall;
		while (sent < n_items) begin
			if ($urandom_range(99) < 35) begin
				it = random_store();
				send_item(it);
				sent++;
				repeat ($urandom_range(3)) begin
					send_item(random_probe({it.side, it.position_key[IDX_W-1:0]}));
					sent++;
				end
			end else begin
				send_item(random_probe(pick_filled()));
				sent++;
			end
		end
	endtask

	task automatic test_back_pressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		repeat (40) begin
			if ($urandom_range(3) == 0)
				send_item(random_store());
			else
				send_item(random_probe(pick_filled()));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(250, 0, 0);
		test_back_pressure();
		test_random(250, 56, 0);
		test_random(250, 0, 56);
		test_random(250, 28, 28);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_lookups.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
